>>> src/asp_pkg.sv
package asp_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int COST_W = 24;
  localparam logic [COST_W-1:0] INF_COST = {COST_W{1'b1}};

  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;
  localparam int VALUE_W = 16;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_HEUR   = 2'd1,
    OP_RUN         = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_START_NODE = 2'd1,
    REG_GOAL_NODE  = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  // Saturating add: results at or above infinity clamp to infinity.
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, INF_COST}) begin
      return INF_COST;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

>>> src/astar_shortest_path_unit.sv
// A* search unit over a loaded adjacency matrix.
// Input channel (in_valid/in_ready): operation 0 writes one edge weight at
// (row, col), operation 1 writes the heuristic of node row, operation 2 runs
// a search from start_node to goal_node. Loads are accepted back to back
// while idle. Operation 3 is dropped.
// Result channel (out_valid/out_ready): a run emits the path start to goal,
// one node per request, last set on the final one, found=1. If the goal is
// unreachable, or start or goal is not below the effective node count, one
// request with node=0, found=0, last=1 comes out.
// With N the effective node count, each expanded node costs an open-set scan
// and a matrix row pass over the N nodes, one memory read per cycle, with the
// SCAN_END and REL_RD states between them. A run starts with a clearing pass
// over all MAX_NODES entries and ends with a walk back along the parent links
// and one emitted request per path node.
// in_ready is low during a run. A stalled receiver holds the result register
// and the sequencer waits on it. Reset (rst_n low, synchronous) returns the
// registers to node_count=64, start=goal=0 and idles the sequencer; the
// weight and heuristic memories keep their contents.
// Configuration is an APB-style port at byte addresses 0, 4, 8.
module astar_shortest_path_unit
  import asp_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [NODE_W-1:0]  in_row,
  input  logic [NODE_W-1:0]  in_col,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  out_node,
  output logic               out_found,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(MAX_NODES * MAX_NODES);
  localparam logic [COUNT_W-1:0] MAXN = COUNT_W'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_SCAN_END, S_REL_RD, S_REL, S_WALK, S_EMIT_WAIT,
    S_EMIT, S_FAIL, S_DONE
  } state_t;

  // Memories.
  logic [WEIGHT_BITS-1:0] wmem [MAX_NODES*MAX_NODES];
  logic [WEIGHT_BITS-1:0] hmem [MAX_NODES];
  logic [COST_W-1:0]      gmem [MAX_NODES];
  logic [COST_W-1:0]      fmem [MAX_NODES];
  logic [IW-1:0]          pmem [MAX_NODES];
  logic [IW-1:0]          smem [MAX_NODES];

  logic [COUNT_W-1:0] node_count_r;
  logic [NODE_W-1:0]  start_r, goal_r;
  logic [MAX_NODES-1:0] open_r, closed_r, haspar_r;

  state_t state_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] cur_r, best_idx_r, walk_r;
  logic          have_r;
  logic [COST_W-1:0] best_r, gcur_r;
  logic [CW-1:0] len_r;
  logic [IW-1:0] pos_r;

  logic [WEIGHT_BITS-1:0] w_rd_r, h_rd_r;
  logic [COST_W-1:0]      g_rd_r, f_rd_r;
  logic [IW-1:0]          s_rd_r;

  logic [NODE_W-1:0] out_node_r;
  logic out_valid_r, out_found_r, out_last_r;

  logic [COUNT_W-1:0] n_eff;
  logic [IW-1:0] idx_lo;
  logic cfg_wr;
  logic [COST_W-1:0] t_sum;
  logic [AW-1:0] w_ld_addr, w_rd_addr;

  assign n_eff  = (node_count_r == '0) ? COUNT_W'(1) :
                  (node_count_r > MAXN) ? MAXN : node_count_r;
  assign idx_lo = idx_r[IW-1:0];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign t_sum = sat_add(gcur_r, COST_W'(w_rd_r));
  assign w_ld_addr = AW'(in_row) * AW'(MAX_NODES) + AW'(in_col);
  assign w_rd_addr = AW'(cur_r) * AW'(MAX_NODES) + AW'(idx_lo);

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[3:2]))
      REG_NODE_COUNT: cfg_prdata = 32'(node_count_r);
      REG_START_NODE: cfg_prdata = 32'(start_r);
      REG_GOAL_NODE:  cfg_prdata = 32'(goal_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= COUNT_W'(64);
      start_r <= '0;
      goal_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[3:2]))
        REG_NODE_COUNT: node_count_r <= cfg_pwdata[COUNT_W-1:0];
        REG_START_NODE: start_r <= cfg_pwdata[NODE_W-1:0];
        REG_GOAL_NODE:  goal_r  <= cfg_pwdata[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Loads. Index bits above the node range drop the request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && op_t'(in_operation) == OP_LOAD_WEIGHT &&
        32'(in_row) < MAX_NODES && 32'(in_col) < MAX_NODES) begin
      wmem[w_ld_addr] <= in_value[WEIGHT_BITS-1:0];
    end
    if (in_valid && in_ready && op_t'(in_operation) == OP_LOAD_HEUR &&
        32'(in_row) < MAX_NODES) begin
      hmem[IW'(in_row)] <= in_value[WEIGHT_BITS-1:0];
    end
  end

  // Registered reads, one address each, selected by the sequencer.
  logic [IW-1:0] rd_addr;
  always_comb begin
    case (state_r)
      S_CLEAR:  rd_addr = IW'(start_r);
      S_REL_RD: rd_addr = cur_r;
      S_WALK:  rd_addr = walk_r;
      S_EMIT_WAIT, S_EMIT: rd_addr = pos_r;
      default: rd_addr = idx_lo;
    endcase
  end

  always_ff @(posedge clk) begin
    w_rd_r <= wmem[w_rd_addr];
    h_rd_r <= hmem[rd_addr];
    g_rd_r <= gmem[rd_addr];
    f_rd_r <= fmem[rd_addr];
    s_rd_r <= smem[rd_addr];
  end

  // Table writes from the sequencer.
  logic          tw_en, sw_en;
  logic [IW-1:0] tw_addr;
  logic [COST_W-1:0] tw_g, tw_f;
  logic [IW-1:0] rel_j;
  logic rel_upd;
  assign rel_j = IW'(idx_r - CW'(1));
  assign rel_upd = (state_r == S_REL) && (idx_r != '0) && (w_rd_r != '0) &&
                   !closed_r[rel_j] && (t_sum < g_rd_r);

  always_comb begin
    tw_en = 1'b0;
    tw_addr = idx_lo;
    tw_g = INF_COST;
    tw_f = INF_COST;
    if (state_r == S_CLEAR) begin
      tw_en = 1'b1;
      if (idx_lo == IW'(start_r)) begin
        tw_g = '0;
        tw_f = COST_W'(h_rd_r);
      end
    end else if (rel_upd) begin
      tw_en = 1'b1;
      tw_addr = rel_j;
      tw_g = t_sum;
      tw_f = sat_add(t_sum, COST_W'(h_rd_r));
    end
  end

  assign sw_en = (state_r == S_WALK);

  always_ff @(posedge clk) begin
    if (tw_en) begin
      gmem[tw_addr] <= tw_g;
      fmem[tw_addr] <= tw_f;
    end
    if (rel_upd) pmem[rel_j] <= cur_r;
    if (sw_en) smem[IW'(len_r)] <= walk_r;
  end

  // Sequencer. Reads issued at idx are registered and appear in the next cycle,
  // so loops run idx one ahead of the element being processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      open_r <= '0;
      closed_r <= '0;
      haspar_r <= '0;
      idx_r <= '0;
      have_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && op_t'(in_operation) == OP_RUN) begin
            open_r <= '0;
            closed_r <= '0;
            haspar_r <= '0;
            if (COUNT_W'(start_r) >= n_eff || COUNT_W'(goal_r) >= n_eff) begin
              state_r <= S_FAIL;
            end else begin
              idx_r <= CW'(start_r);
              state_r <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          // The first cycle marks start open. The sweep then writes every
          // entry; start gets its heuristic, read at start_r throughout.
          if (idx_lo == IW'(start_r) && !open_r[IW'(start_r)]) begin
            open_r[IW'(start_r)] <= 1'b1;
            idx_r <= '0;
          end else if (idx_r == CW'(MAX_NODES - 1)) begin
            idx_r <= '0;
            have_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_SCAN: begin
          if (idx_r != '0) begin
            if (open_r[IW'(idx_r - CW'(1))] &&
                (!have_r || f_rd_r < best_r)) begin
              have_r <= 1'b1;
              best_r <= f_rd_r;
              best_idx_r <= IW'(idx_r - CW'(1));
            end
          end
          if (idx_r == CW'(n_eff)) state_r <= S_SCAN_END;
          else idx_r <= idx_r + CW'(1);
        end
        S_SCAN_END: begin
          if (!have_r) begin
            state_r <= S_FAIL;
          end else if (best_idx_r == IW'(goal_r)) begin
            walk_r <= best_idx_r;
            len_r <= '0;
            state_r <= S_WALK;
          end else begin
            cur_r <= best_idx_r;
            open_r[best_idx_r] <= 1'b0;
            closed_r[best_idx_r] <= 1'b1;
            idx_r <= '0;
            state_r <= S_REL_RD;
          end
        end
        S_REL_RD: begin
          // Issue the read of the current node's cost; S_REL captures it.
          idx_r <= '0;
          state_r <= S_REL;
        end
        S_REL: begin
          if (idx_r == '0) begin
            gcur_r <= g_rd_r;
          end else begin
            if (w_rd_r != '0 && !closed_r[rel_j]) begin
              open_r[rel_j] <= 1'b1;
              if (rel_upd) haspar_r[rel_j] <= 1'b1;
            end
          end
          if (idx_r == CW'(n_eff)) begin
            idx_r <= '0;
            have_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_WALK: begin
          len_r <= len_r + CW'(1);
          if (!haspar_r[walk_r] || len_r == CW'(MAX_NODES - 1)) begin
            pos_r <= IW'(len_r);
            state_r <= S_EMIT_WAIT;
          end else begin
            walk_r <= pmem[walk_r];
          end
        end
        S_EMIT_WAIT: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_node_r <= NODE_W'(s_rd_r);
            out_found_r <= 1'b1;
            out_last_r <= (pos_r == '0);
            if (pos_r == '0) begin
              state_r <= S_DONE;
            end else begin
              pos_r <= pos_r - IW'(1);
              state_r <= S_EMIT_WAIT;
            end
          end
        end
        S_FAIL: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_node_r <= '0;
            out_found_r <= 1'b0;
            out_last_r <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r != S_EMIT && state_r != S_FAIL && state_r != S_DONE &&
          out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_node  = out_node_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

  a_closed_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((open_r & closed_r) == '0))
    else $error("node both open and closed");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_node) && $stable(out_last)))
    else $error("result dropped while stalled");

endmodule

>>> verif/testbench.sv
module testbench;
  import asp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic              last;
  } path_step_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation;
  logic [NODE_W-1:0]  in_row;
  logic [NODE_W-1:0]  in_col;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [NODE_W-1:0]  out_node;
  logic               out_found;
  logic               out_last;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [3:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  astar_shortest_path_unit dut (.*);

  // Mirror of the block's stores and registers.
  logic [VALUE_W-1:0] edge_w [MAX_NODES_DEF*MAX_NODES_DEF];
  logic [VALUE_W-1:0] heur_v [MAX_NODES_DEF];
  logic [COUNT_W-1:0] mdl_count;
  logic [NODE_W-1:0]  mdl_start;
  logic [NODE_W-1:0]  mdl_goal;

  path_step_t expected_path_q[$];
  int errors;
  int runs_sent;
  int steps_seen;
  int unreach_seen;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [COST_W-1:0] clamp_cost(input logic [COST_W-1:0] a,
                                                   input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, INF_COST}) ? INF_COST : s[COST_W-1:0];
  endfunction

  function automatic void push_step(input int node, input bit found, input bit last);
    path_step_t st;
    st.node = NODE_W'(node);
    st.found = found;
    st.last = last;
    expected_path_q = {expected_path_q, st};
  endfunction

  function automatic void predict_search();
    logic [COST_W-1:0] g [MAX_NODES_DEF];
    logic [COST_W-1:0] f [MAX_NODES_DEF];
    logic [6:0]        par [MAX_NODES_DEF];
    int                stk [MAX_NODES_DEF];
    logic [63:0]       opn;
    logic [63:0]       cls;
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] t;
    logic [COST_W-1:0] w;
    bit                have;
    int                n;
    int                cur;
    int                j;
    int                len;
    n = mdl_count;
    if (n == 0) n = 1;
    if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      g[i] = INF_COST;
      f[i] = INF_COST;
      par[i] = 7'h7F;
    end
    cls = '0;
    if (mdl_start >= n || mdl_goal >= n) begin
      push_step(0, 1'b0, 1'b1);
      return;
    end
    g[mdl_start] = '0;
    f[mdl_start] = clamp_cost('0, COST_W'(heur_v[mdl_start]));
    opn = 64'd1 << mdl_start;
    while (opn != 0) begin
      have = 1'b0;
      best = INF_COST;
      cur = 0;
      for (int i = 0; i < n; i++) begin
        if (opn[i] && (!have || f[i] < best)) begin
          have = 1'b1;
          best = f[i];
          cur = i;
        end
      end
      if (cur == mdl_goal) begin
        len = 0;
        j = cur;
        while (len < MAX_NODES_DEF) begin
          stk[len] = j;
          len++;
          if (par[j] == 7'h7F) break;
          j = par[j] % MAX_NODES_DEF;
        end
        for (int k = 0; k < len; k++) begin
          push_step(stk[len-1-k], 1'b1, k == len - 1);
        end
        return;
      end
      opn[cur] = 1'b0;
      cls[cur] = 1'b1;
      for (int d = 0; d < n; d++) begin
        w = COST_W'(edge_w[cur*MAX_NODES_DEF + d]);
        if (w == 0 || cls[d]) continue;
        opn[d] = 1'b1;
        t = clamp_cost(g[cur], w);
        if (t >= g[d]) continue;
        par[d] = 7'(cur);
        g[d] = t;
        f[d] = clamp_cost(t, COST_W'(heur_v[d]));
      end
    end
    push_step(0, 1'b0, 1'b1);
  endfunction

  // Sends one request and updates the mirror when it is accepted.
  task automatic send_item(input op_t op, input int row, input int col, input int value);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_row <= NODE_W'(row);
    in_col <= NODE_W'(col);
    in_value <= VALUE_W'(value);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_LOAD_WEIGHT: edge_w[row*MAX_NODES_DEF + col] = VALUE_W'(value);
      OP_LOAD_HEUR:   heur_v[row] = VALUE_W'(value);
      OP_RUN: begin
        runs_sent++;
        predict_search();
      end
      default: ;
    endcase
  endtask

  // Holds the sender until every expected result is in and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_path_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input int value);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx * 4);
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_NODE_COUNT: mdl_count = COUNT_W'(value);
      REG_START_NODE: mdl_start = NODE_W'(value);
      REG_GOAL_NODE:  mdl_goal = NODE_W'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic int rand_weight(input int density);
    if ($urandom_range(0, 99) >= density) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 65535);
    return $urandom_range(1, 20);
  endfunction

  // Writes every weight and heuristic below n, so a search never reads stale entries.
  task automatic load_graph(input int n, input int density);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        send_item(OP_LOAD_WEIGHT, r, c, rand_weight(density));
        if ($urandom_range(0, 30) == 0) send_item(OP_NONE, $urandom, $urandom, $urandom);
      end
    end
    for (int r = 0; r < n; r++) begin
      send_item(OP_LOAD_HEUR, r, $urandom, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8));
    end
  endtask

  task automatic set_path(input int s, input int g);
    cfg_write(REG_START_NODE, s);
    cfg_write(REG_GOAL_NODE, g);
  endtask

  task automatic test_directed();
    // Single node: start and goal coincide.
    cfg_write(REG_NODE_COUNT, 1);
    send_item(OP_LOAD_WEIGHT, 0, 0, 0);
    send_item(OP_LOAD_HEUR, 0, 0, 16'hFFFF);
    send_item(OP_RUN, 0, 0, 0);
    // Diamond with equal branches, so the tie goes to the lower index.
    cfg_write(REG_NODE_COUNT, 4);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) send_item(OP_LOAD_WEIGHT, r, c, 0);
      send_item(OP_LOAD_HEUR, r, 0, 0);
    end
    send_item(OP_LOAD_WEIGHT, 0, 1, 5);
    send_item(OP_LOAD_WEIGHT, 0, 2, 5);
    send_item(OP_LOAD_WEIGHT, 1, 3, 16'hFFFF);
    send_item(OP_LOAD_WEIGHT, 2, 3, 16'hFFFF);
    set_path(0, 3);
    send_item(OP_RUN, 63, 63, 16'hFFFF);
    send_item(OP_NONE, 63, 63, 16'hFFFF);
    set_path(3, 3);
    send_item(OP_RUN, 0, 0, 0);
    // Goal outside the active nodes.
    set_path(0, 63);
    send_item(OP_RUN, 0, 0, 0);
    // Cut both branches: unreachable goal.
    send_item(OP_LOAD_WEIGHT, 1, 3, 0);
    send_item(OP_LOAD_WEIGHT, 2, 3, 0);
    set_path(0, 3);
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_LOAD_WEIGHT, 63, 63, 16'hFFFF);
    send_item(OP_LOAD_HEUR, 63, 0, 16'hFFFF);
  endtask

  task automatic test_random_graphs();
    int n;
    for (int p = 0; p < 6; p++) begin
      n = $urandom_range(2, 6);
      cfg_write(REG_NODE_COUNT, n);
      load_graph(n, $urandom_range(15, 70));
      for (int k = 0; k < 5; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          set_path($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
          set_path($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end
        send_item(OP_RUN, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 1) == 0) send_item(OP_RUN, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0) send_item(OP_NONE, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_long_chain();
    cfg_write(REG_NODE_COUNT, 9);
    load_graph(9, 10);
    // A chain keeps every node reachable and the paths long.
    for (int r = 0; r < 8; r++) send_item(OP_LOAD_WEIGHT, r, r + 1, $urandom_range(1, 65535));
    set_path(0, 8);
    send_item(OP_RUN, 0, 0, 0);
    set_path($urandom_range(0, 3), $urandom_range(4, 8));
    send_item(OP_RUN, 0, 0, 0);
    // Zero count acts as one node, an oversized count as the full table.
    // Start equals goal here, so only the start heuristic is read.
    cfg_write(REG_NODE_COUNT, 0);
    set_path(0, 0);
    send_item(OP_RUN, 0, 0, 0);
    cfg_write(REG_NODE_COUNT, 127);
    set_path(63, 63);
    send_item(OP_RUN, 0, 0, 0);
  endtask

  // Receiver: draws a stall before each result.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_path_q.size() == 0) begin
        $error("unexpected result: node %0d found %0b last %0b", out_node, out_found, out_last);
        errors++;
      end else begin
        path_step_t exp_st;
        exp_st = expected_path_q.pop_front();
        steps_seen++;
        if (!exp_st.found) unreach_seen++;
        if (out_node !== exp_st.node) begin
          $error("node: expected %0d, actual %0d", exp_st.node, out_node);
          errors++;
        end
        if (out_found !== exp_st.found) begin
          $error("found: expected %0b, actual %0b", exp_st.found, out_found);
          errors++;
        end
        if (out_last !== exp_st.last) begin
          $error("last: expected %0b, actual %0b", exp_st.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    errors = 0;
    runs_sent = 0;
    steps_seen = 0;
    unreach_seen = 0;
    mdl_count = 7'd64;
    mdl_start = '0;
    mdl_goal = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_NONE;
    in_row <= '0;
    in_col <= '0;
    in_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_graphs();
    test_long_chain();
    drain();
    $display("Ran %0d searches on graphs of up to 9 nodes and on clamped node counts,", runs_sent);
    $display("under random stalls; checked %0d path results, %0d without a path.",
             steps_seen, unreach_seen);
    if (errors == 0 && expected_path_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
